// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word width, register indexes, reset values and the controller state type
// shared by the interfaces, the serial multiplier and the top level.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of the base, the modulus, the exponent and the result.
  localparam int WORD_BITS  = 32;
  // Bits of the serial bit counter inside the multiplier.
  localparam int COUNT_BITS = $clog2(WORD_BITS);
  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = CFG_INDEX_BITS'(1);

  // Register values after reset.
  localparam word_t MODULUS_RESET  = WORD_BITS'(3233);
  localparam word_t EXPONENT_RESET = WORD_BITS'(17);

  localparam word_t WORD_ONE = WORD_BITS'(1);

  // Exponentiation controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LAUNCH,
    ST_STEP,
    ST_FINISH
  } mexp_state_t;

endpackage

// ===== hw/rtl/mexp_ifs.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the base operand, the result and register writes.
// ----------------------------------------------------------------------------

// Operand channel: one base value per item.
interface mexp_operand_if
  import mexp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

// Result channel: one power result per item.
interface mexp_result_if
  import mexp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// Configuration write channel: register index and write data.
interface mexp_cfg_if
  import mexp_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  word_t                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Forms (mult_a * mult_b) mod modulus by shift-and-add, scanning mult_b from
// its top bit. Each multiplier bit is a modular doubling followed by a
// conditional modular add of mult_a. A modulus of zero wraps at the
// word width. The product appears on product with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t mult_a,
  input  word_t mult_b,
  input  word_t modulus,
  output logic  done,
  output word_t product
);

  logic                  busy;
  logic                  phase;
  logic [COUNT_BITS-1:0] count;
  word_t                 acc;
  word_t                 a_reg;
  word_t                 b_shift;
  word_t                 addend;
  logic [WORD_BITS:0]    sum;
  word_t                 acc_next;

  // Doubling phase adds the accumulator to itself; the add phase adds the
  // multiplicand when the current multiplier bit is set.
  always_comb begin
    if (phase) begin
      addend = b_shift[WORD_BITS-1] ? a_reg : '0;
    end else begin
      addend = acc;
    end
    sum = {1'b0, acc} + {1'b0, addend};
    if (modulus == '0) begin
      acc_next = sum[WORD_BITS-1:0];
    end else if (sum >= {1'b0, modulus}) begin
      acc_next = WORD_BITS'(sum - {1'b0, modulus});
    end else begin
      acc_next = sum[WORD_BITS-1:0];
    end
  end

  // Sequencing of the bit count and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
      done  <= 1'b0;
    end else if (busy) begin
      phase <= ~phase;
      if (phase && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Accumulator and operand shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      a_reg   <= mult_a;
      b_shift <= mult_b;
      count   <= COUNT_BITS'(WORD_BITS - 1);
    end else if (busy) begin
      acc <= acc_next;
      if (phase) begin
        b_shift <= b_shift << 1;
        count   <= count - 1'b1;
      end
    end
  end

  assign product = acc;

`ifndef NO_ASSERTIONS
  // A new product is only started once the previous one is finished.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("multiplier restarted while busy");

  // The add phase of the last bit ends the product.
  a_last_bit_done: assert property (@(posedge clk) disable iff (rst)
    busy && phase && count == '0 && !start |=> done && !busy)
    else $error("multiplier did not finish after its last bit");

  // The done pulse never overlaps an active product.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while still busy");
`endif

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Raises each base value to the configured exponent, reduced by the
// configured modulus, by right-to-left square-and-multiply over two
// bit-serial modular multipliers.
// ----------------------------------------------------------------------------
//
//   Port      Role    Payload
//   --------  ------  ---------------------------------------------
//   cfg       sink    index (0 modulus, 1 exponent), data
//   operand   sink    base_value
//   result    source  power_result
//
// The base is first reduced by the modulus. For each exponent bit up to the
// highest set one, the running product and the square are then formed at
// once in two multipliers, and the finish state passes the result to the
// output register. Items are worked one at a time; the next base is taken
// while the last result still waits in the output register. Reset is
// synchronous and restores modulus 3233 and exponent 17. A stalled result
// channel holds the finished item in the controller until the output
// register frees.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mexp_cfg_if.sink     cfg,
  mexp_operand_if.sink operand,
  mexp_result_if.source result
);

  mexp_state_t state;
  mexp_state_t state_next;

  word_t modulus;
  word_t exponent;
  word_t exp_rem;
  word_t acc;
  word_t sq;
  word_t power;
  logic  out_valid;

  logic  start_a;
  logic  start_b;
  word_t mult_a_op;
  word_t mult_b_op;
  logic  done_a;
  logic  done_b;
  word_t prod_a;
  word_t prod_b;

  // Configuration registers are always ready to be written.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RESET;
      exponent <= EXPONENT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MODULUS:  modulus  <= cfg.data;
        CFG_EXPONENT: exponent <= cfg.data;
        default:      ;
      endcase
    end
  end

  // Multiplier A reduces the base, then forms the running product.
  mexp_mulmod u_mul_acc (
    .clk     (clk),
    .rst     (rst),
    .start   (start_a),
    .mult_a  (mult_a_op),
    .mult_b  (mult_b_op),
    .modulus (modulus),
    .done    (done_a),
    .product (prod_a)
  );

  // Multiplier B squares the current power of the base.
  mexp_mulmod u_mul_sq (
    .clk     (clk),
    .rst     (rst),
    .start   (start_b),
    .mult_a  (sq),
    .mult_b  (sq),
    .modulus (modulus),
    .done    (done_b),
    .product (prod_b)
  );

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign operand.ready = (state == ST_IDLE);

  // Next state and multiplier launches.
  always_comb begin
    state_next = state;
    start_a    = 1'b0;
    start_b    = 1'b0;
    mult_a_op  = acc;
    mult_b_op  = sq;
    case (state)
      ST_IDLE: begin
        if (operand.valid) begin
          // Base mod modulus is formed as 1 * base.
          start_a    = 1'b1;
          mult_a_op  = WORD_ONE;
          mult_b_op  = operand.base_value;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (done_a) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (exp_rem == '0) begin
          state_next = ST_FINISH;
        end else begin
          start_a    = 1'b1;
          start_b    = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (done_b) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Exponent scan, running product and square.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && operand.valid) begin
      exp_rem <= exponent;
      acc     <= WORD_ONE;
    end
    if (state == ST_REDUCE && done_a) begin
      sq <= prod_a;
    end
    if (state == ST_STEP && done_b) begin
      if (exp_rem[0]) begin
        acc <= prod_a;
      end
      sq      <= prod_b;
      exp_rem <= exp_rem >> 1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || result.ready)) begin
      power <= acc;
    end
  end

  assign result.valid        = out_valid;
  assign result.power_result = power;

`ifndef NO_ASSERTIONS
  // Both multipliers of one exponent step run in lockstep.
  a_step_lockstep: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> done_a == done_b)
    else $error("running product and square finished apart");

  // The exponent is fully consumed before a result is produced.
  a_finish_exp_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> exp_rem == '0)
    else $error("result produced with exponent bits left");

  // The square multiplier never runs during the base reduction.
  a_reduce_single: assert property (@(posedge clk) disable iff (rst)
    state == ST_REDUCE |-> !start_b && !done_b)
    else $error("square multiplier active during base reduction");
`endif

endmodule

// ===== bench/modular_exponentiation_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Writes modulus and exponent settings between phases, sends base values
// with random gaps while the result side stalls at random, and compares
// every power result with a square-and-multiply predictor kept in the bench.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_test;
  import mexp_pkg::*;

  // Register indexes that map to nothing; writes to them must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_FIRST = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_LAST  = CFG_INDEX_BITS'(3);

  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 246;
  localparam int TAIL_ITEMS    = 24;
  localparam int DRAIN_SETTLE  = 4;
  localparam int END_SETTLE    = 4 * WORD_BITS;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 8_000_000;

  typedef enum logic [1:0] {
    WORK_BASE,
    WORK_WRITE,
    WORK_DRAIN
  } work_kind_t;

  typedef struct {
    work_kind_t                kind;
    logic [CFG_INDEX_BITS-1:0] index;
    word_t                     value;
    int                        gap;
  } pending_work_t;

  logic clk = 1'b0;
  logic rst;

  mexp_cfg_if     cfg_bus ();
  mexp_operand_if operand_bus ();
  mexp_result_if  result_bus ();

  modular_exponentiation_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .operand (operand_bus),
    .result  (result_bus)
  );

  pending_work_t pending_work[$];
  word_t         expected_powers[$];
  int            failures = 0;
  bit            quiet_sender = 1'b0;

  // Register copies as the block should hold them.
  word_t modulus_now;
  word_t exponent_now;

  // Driver and monitor bookkeeping.
  int   send_idle;
  int   drain_cycles;
  logic op_next;
  logic cfg_next;
  int   stall_left;
  int   calm_left;
  logic ready_next;
  word_t wanted;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Product of two words under the modulus; a zero modulus wraps at the word.
  function automatic word_t mod_product(word_t a, word_t b, word_t modv);
    logic [2*WORD_BITS-1:0] full;
    full = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
    if (modv == '0) return full[WORD_BITS-1:0];
    return word_t'(full % {{WORD_BITS{1'b0}}, modv});
  endfunction

  // Right-to-left square-and-multiply over the exponent bits.
  function automatic word_t predict_power(word_t base, word_t modv, word_t expv);
    word_t acc;
    word_t sq;
    word_t bits;
    acc  = WORD_ONE;
    sq   = base;
    bits = expv;
    if (modv != '0) sq = sq % modv;
    while (bits != '0) begin
      if (bits[0]) acc = mod_product(acc, sq, modv);
      sq   = mod_product(sq, sq, modv);
      bits = bits >> 1;
    end
    return acc;
  endfunction

  // Queue one piece of work, with an idle burst ahead of it now and then.
  task automatic add_work(work_kind_t kind, logic [CFG_INDEX_BITS-1:0] index,
                          word_t value);
    pending_work_t w;
    w.kind  = kind;
    w.index = index;
    w.value = value;
    w.gap   = (quiet_sender || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6);
    pending_work.push_back(w);
  endtask

  // Wait for the block to go idle, then load both registers.
  task automatic reconfigure(word_t modv, word_t expv);
    add_work(WORK_DRAIN, CFG_MODULUS, '0);
    add_work(WORK_WRITE, CFG_MODULUS, modv);
    add_work(WORK_WRITE, CFG_EXPONENT, expv);
  endtask

  // Driver: feeds base values and register writes from the pending queue and
  // predicts the power result of every base the block accepts.
  always @(posedge clk) begin
    if (rst) begin
      operand_bus.valid <= 1'b0;
      cfg_bus.valid     <= 1'b0;
      modulus_now  = MODULUS_RESET;
      exponent_now = EXPONENT_RESET;
      send_idle    = 0;
      drain_cycles = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_MODULUS:  modulus_now  = cfg_bus.data;
          CFG_EXPONENT: exponent_now = cfg_bus.data;
          default: ;
        endcase
      end
      if (operand_bus.valid && operand_bus.ready) begin
        expected_powers.push_back(
          predict_power(operand_bus.base_value, modulus_now, exponent_now));
      end

      op_next  = operand_bus.valid && !operand_bus.ready;
      cfg_next = cfg_bus.valid && !cfg_bus.ready;
      if (!op_next && !cfg_next) begin
        if (send_idle > 0) begin
          send_idle--;
        end else if (pending_work.size() > 0) begin
          if (pending_work[0].gap > 0) begin
            send_idle = pending_work[0].gap - 1;
            pending_work[0].gap = 0;
          end else begin
            case (pending_work[0].kind)
              WORK_BASE: begin
                op_next = 1'b1;
                operand_bus.base_value <= pending_work[0].value;
                void'(pending_work.pop_front());
              end
              WORK_WRITE: begin
                cfg_next = 1'b1;
                cfg_bus.index <= pending_work[0].index;
                cfg_bus.data  <= pending_work[0].value;
                void'(pending_work.pop_front());
              end
              default: begin
                // Hold off until every result is in and the block has settled.
                if (expected_powers.size() != 0) begin
                  drain_cycles = 0;
                end else if (drain_cycles >= DRAIN_SETTLE) begin
                  drain_cycles = 0;
                  void'(pending_work.pop_front());
                end else begin
                  drain_cycles++;
                end
              end
            endcase
          end
        end
      end
      operand_bus.valid <= op_next;
      cfg_bus.valid     <= cfg_next;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the result channel in random bursts, with calm stretches between.
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_powers.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected power_result %h with no base pending",
                     result_bus.power_result);
        end else begin
          wanted = expected_powers.pop_front();
          if (result_bus.power_result !== wanted) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("power_result mismatch: expected %h, got %h",
                       wanted, result_bus.power_result);
          end
        end
      end

      ready_next = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (pending_work.size() <= TAIL_ITEMS) begin
        calm_left = 0;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 63) == 0) begin
        calm_left = $urandom_range(50, 400);
      end else if ($urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        ready_next = 1'b0;
      end
      result_bus.ready <= ready_next;
    end
  end

  // Stimulus: directed corners, random phases, then a quiet closing phase.
  initial begin
    word_t modv;
    word_t expv;
    word_t base;
    int    random_sent;
    int    phase_items;
    int    w;

    rst = 1'b1;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_MODULUS;
    cfg_bus.data           = '0;
    operand_bus.valid      = 1'b0;
    operand_bus.base_value = '0;
    result_bus.ready       = 1'b0;

    // Reset settings: zero, one, bases at and beyond the modulus, all ones.
    add_work(WORK_BASE, CFG_MODULUS, '0);
    add_work(WORK_BASE, CFG_MODULUS, WORD_ONE);
    add_work(WORK_BASE, CFG_MODULUS, MODULUS_RESET - 1);
    add_work(WORK_BASE, CFG_MODULUS, MODULUS_RESET);
    add_work(WORK_BASE, CFG_MODULUS, '1);
    add_work(WORK_BASE, CFG_MODULUS, word_t'(65));

    // Writes to unmapped indexes leave both registers untouched.
    add_work(WORK_DRAIN, CFG_MODULUS, '0);
    add_work(WORK_WRITE, CFG_UNMAPPED_FIRST, '1);
    add_work(WORK_WRITE, CFG_UNMAPPED_LAST, word_t'(7));
    add_work(WORK_BASE, CFG_MODULUS, word_t'(65));
    add_work(WORK_BASE, CFG_MODULUS, 32'hAAAA_AAAA);

    // Zero exponent gives one even under a modulus of one.
    reconfigure(WORD_ONE, '0);
    add_work(WORK_BASE, CFG_MODULUS, '0);
    add_work(WORK_BASE, CFG_MODULUS, '1);

    // Modulus of one with a nonzero exponent gives zero.
    reconfigure(WORD_ONE, word_t'(5));
    add_work(WORK_BASE, CFG_MODULUS, 32'h5555_5555);
    add_work(WORK_BASE, CFG_MODULUS, '1);

    // Largest modulus and longest exponent.
    reconfigure('1, '1);
    add_work(WORK_BASE, CFG_MODULUS, 32'hFFFF_FFFE);
    add_work(WORK_BASE, CFG_MODULUS, 32'h1234_5678);

    // Zero modulus: products wrap at the word width.
    reconfigure('0, word_t'(32'h1_0001));
    add_work(WORK_BASE, CFG_MODULUS, '1);
    add_work(WORK_BASE, CFG_MODULUS, word_t'(3));
    add_work(WORK_BASE, CFG_MODULUS, 32'h8000_0000);

    // Smallest reducing modulus, then the matching private exponent.
    reconfigure(word_t'(2), WORD_ONE);
    add_work(WORK_BASE, CFG_MODULUS, '1);
    add_work(WORK_BASE, CFG_MODULUS, 32'h8000_0000);
    reconfigure(MODULUS_RESET, word_t'(2753));
    add_work(WORK_BASE, CFG_MODULUS, word_t'(2790));

    // Random phases: a fresh setting each time, mostly short exponents.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 11))
        0:       modv = WORD_ONE;
        1:       modv = '0;
        2:       modv = '1;
        3:       modv = $urandom_range(2, 255);
        4:       modv = $urandom_range(256, 65535);
        5:       modv = $urandom | 32'h8000_0000;
        default: modv = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: expv = '0;
        1: expv = $urandom;
        default: begin
          w    = $urandom_range(1, 10);
          expv = ($urandom & ((32'd1 << w) - 1)) | (32'd1 << (w - 1));
        end
      endcase
      reconfigure(modv, expv);
      if ($urandom_range(0, 3) == 0)
        add_work(WORK_WRITE, ($urandom_range(0, 1) == 0) ? CFG_UNMAPPED_FIRST
                                                         : CFG_UNMAPPED_LAST,
                 $urandom);

      phase_items = (expv >= 32'h1_0000) ? $urandom_range(2, 5)
                                         : $urandom_range(8, 30);
      repeat (phase_items) begin
        case ($urandom_range(0, 9))
          0:       base = '0;
          1:       base = WORD_ONE;
          2:       base = modv - 1;
          3:       base = modv;
          4:       base = '1;
          5, 6:    base = $urandom_range(0, (modv == '0) ? '1 : modv - 1);
          default: base = $urandom;
        endcase
        add_work(WORK_BASE, CFG_MODULUS, base);
      end
      random_sent += phase_items;
    end

    // Closing phase with no idling on either side.
    quiet_sender = 1'b1;
    reconfigure($urandom | WORD_ONE, $urandom_range(3, 255));
    repeat (TAIL_ITEMS) add_work(WORK_BASE, CFG_MODULUS, $urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait until all work is sent and every predicted result has come back.
    @(posedge clk);
    while (pending_work.size() != 0 || operand_bus.valid || cfg_bus.valid ||
           expected_powers.size() != 0)
      @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    if (expected_powers.size() != 0) begin
      failures += expected_powers.size();
      $display("%0d power results never arrived", expected_powers.size());
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
